// ===== design/amp2mb_pkg.sv =====
package amp2mb_pkg;

    // Default number of fraction bits in the fixed point log2.
    localparam int LOG_FRAC_BITS_DEF = 24;

    // Register indexes of the configuration port.
    localparam logic CFG_FLOOR_THRESHOLD = 1'b0;
    localparam logic CFG_SCALE           = 1'b1;

    // Reset values of the configuration registers.
    localparam logic [31:0] FLOOR_THRESH_RST = 32'h3727_C5AC;
    localparam logic [15:0] SCALE_RST        = 16'd2000;

    // log10(2) as Q0.32, rounded to nearest.
    localparam logic [31:0] LOG10_2_Q32 = 32'h4D10_4D42;

    // Floor level and the magnitude at which computed levels are clamped.
    localparam logic signed [14:0] FLOOR_LEVEL  = -15'sd10000;
    localparam int unsigned        LEVEL_CLAMP  = 10000;
    localparam logic [7:0]         EXP_BIAS     = 8'd127;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MULM,
        S_SQ,
        S_LOG,
        S_P0,
        S_P1,
        S_P2,
        S_P3,
        S_CLAMP,
        S_OUT
    } t_state;

    function automatic logic is_nan(input logic [31:0] b);
        return (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
    endfunction

    // Unsigned key that orders IEEE single patterns like their values.
    function automatic logic [31:0] order_key(input logic [31:0] b);
        logic [31:0] z;
        z = (b[30:0] == 31'd0) ? 32'd0 : b;
        return z[31] ? ~z : (z | 32'h8000_0000);
    endfunction

endpackage

// ===== design/amplitude_to_millibel.sv =====
// Amplitude to millibel converter.
//
// An IEEE single amplitude word enters on the input channel (i_valid /
// o_ready) and one level word leaves on the output channel (o_valid /
// i_ready). The level is trunc(scale * log10(x)), clamped to -10000..0,
// with o_floored set when the floor rule gave -10000.
// The block works on one word at a time. A single 32 by 32 bit multiplier
// does all the multiplications: one product forms scale * log10(2), then
// LOG_FRAC_BITS squarings of the mantissa give the log2 fraction one bit
// each, and four partial products scale the log. A word that needs the
// full computation passes through S_MULM, S_SQ, S_LOG, S_P0 to S_P3,
// S_CLAMP and S_OUT to the output register, and no new word is accepted
// until the sequencer is back in S_IDLE. NaN, infinity, zero, negative,
// subnormal, large and below-threshold words skip the arithmetic: they
// go from S_IDLE straight to S_OUT and from there to the output register.
// The result sits in an output register, so the next word is accepted
// while it waits; a stalled receiver only holds a finished result back
// from that register. Synchronous reset clears the sequencer and the
// output valid and restores the configuration registers.
module amplitude_to_millibel
    import amp2mb_pkg::*;
#(
    parameter int LOG_FRAC_BITS = LOG_FRAC_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // Configuration write port.
    input  logic               i_cfg_we,
    input  logic               i_cfg_idx,
    input  logic [31:0]        i_cfg_data,
    // Input channel.
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [31:0]        i_amplitude_bits,
    // Output channel.
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [14:0] o_level_millibel,
    output logic               o_floored
);

    // Width of |log2(x)| in fixed point: seven integer bits cover 1..126.
    localparam int AW = LOG_FRAC_BITS + 7;
    // Width of the full product |log2(x)| * scale * log10(2).
    localparam int PW = AW + 48;
    // Width of the integer level after dropping the fraction bits.
    localparam int QW = PW - LOG_FRAC_BITS - 32;
    localparam int CW = $clog2(LOG_FRAC_BITS);

    t_state                    r_state, n_state;
    logic [31:0]               r_thresh;
    logic [15:0]               r_scale;
    logic [30:0]               r_v, n_v;
    logic [6:0]                r_ediff, n_ediff;
    logic [CW-1:0]             r_cnt, n_cnt;
    logic [LOG_FRAC_BITS-1:0]  r_frac, n_frac;
    logic [47:0]               r_m, n_m;
    logic [AW-1:0]             r_a, n_a;
    logic [PW-1:0]             r_acc, n_acc;
    logic signed [14:0]        r_res_level, n_res_level;
    logic                      r_res_fl, n_res_fl;
    logic                      r_o_valid, n_o_valid;
    logic signed [14:0]        r_o_level, n_o_level;
    logic                      r_o_floored, n_o_floored;

    logic                      in_acc;
    logic [7:0]                x_exp;
    logic                      x_nan, x_below, x_nonpos, x_big;
    logic [31:0]               mul_a, mul_b;
    logic [63:0]               mul_p;
    logic [31:0]               sq;
    logic [63:0]               a_ext;
    logic [PW-1:0]             addend;
    logic [QW-1:0]             q, q_neg;
    logic                      out_free;

    assign in_acc   = i_valid && o_ready;
    assign out_free = !r_o_valid || i_ready;

    // Classification of the incoming word, in the order the rules apply.
    assign x_exp    = i_amplitude_bits[30:23];
    assign x_nan    = is_nan(i_amplitude_bits);
    assign x_below  = !is_nan(r_thresh)
                      && (order_key(i_amplitude_bits) < order_key(r_thresh));
    assign x_nonpos = i_amplitude_bits[31] || (x_exp == 8'd0);
    assign x_big    = x_exp >= EXP_BIAS;

    // The shared multiplier and its operand selection.
    assign a_ext = 64'(r_a);

    always_comb begin
        case (r_state)
            S_MULM: begin
                mul_a = 32'(r_scale);
                mul_b = LOG10_2_Q32;
            end
            S_SQ: begin
                mul_a = 32'(r_v);
                mul_b = 32'(r_v);
            end
            S_P0: begin
                mul_a = a_ext[31:0];
                mul_b = r_m[31:0];
            end
            S_P1: begin
                mul_a = a_ext[31:0];
                mul_b = 32'(r_m[47:32]);
            end
            S_P2: begin
                mul_a = a_ext[63:32];
                mul_b = r_m[31:0];
            end
            S_P3: begin
                mul_a = a_ext[63:32];
                mul_b = 32'(r_m[47:32]);
            end
            default: begin
                mul_a = 32'd0;
                mul_b = 32'd0;
            end
        endcase
    end

    assign mul_p = 64'(mul_a) * 64'(mul_b);
    // The square of a Q1.30 value in [1, 2) is below 4, so 32 bits hold it.
    assign sq    = mul_p[61:30];

    always_comb begin
        case (r_state)
            S_P1, S_P2: addend = PW'(mul_p) << 32;
            S_P3:       addend = PW'(mul_p) << 64;
            default:    addend = PW'(mul_p);
        endcase
    end

    assign q     = r_acc[PW-1 -: QW];
    assign q_neg = QW'(0) - q;

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if (x_nan || x_below || x_nonpos || x_big) begin
                        n_state = S_OUT;
                    end else begin
                        n_state = S_MULM;
                    end
                end
            end
            S_MULM:  n_state = S_SQ;
            S_SQ: begin
                if (r_cnt == CW'(0)) begin
                    n_state = S_LOG;
                end
            end
            S_LOG:   n_state = S_P0;
            S_P0:    n_state = S_P1;
            S_P1:    n_state = S_P2;
            S_P2:    n_state = S_P3;
            S_P3:    n_state = S_CLAMP;
            S_CLAMP: n_state = S_OUT;
            S_OUT: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Datapath and outputs.
    always_comb begin
        n_v         = r_v;
        n_ediff     = r_ediff;
        n_cnt       = r_cnt;
        n_frac      = r_frac;
        n_m         = r_m;
        n_a         = r_a;
        n_acc       = r_acc;
        n_res_level = r_res_level;
        n_res_fl    = r_res_fl;
        n_o_valid   = r_o_valid && !i_ready;
        n_o_level   = r_o_level;
        n_o_floored = r_o_floored;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_v     = {1'b1, i_amplitude_bits[22:0], 7'd0};
                    n_ediff = 7'(EXP_BIAS - x_exp);
                    if (x_nan) begin
                        n_res_level = 15'sd0;
                        n_res_fl    = 1'b0;
                    end else if (x_below || x_nonpos) begin
                        n_res_level = FLOOR_LEVEL;
                        n_res_fl    = 1'b1;
                    end else begin
                        // Infinity and any word of one or more give level 0.
                        n_res_level = 15'sd0;
                        n_res_fl    = 1'b0;
                    end
                end
            end
            S_MULM: begin
                n_m   = mul_p[47:0];
                n_cnt = CW'(LOG_FRAC_BITS - 1);
            end
            S_SQ: begin
                n_frac = {r_frac[LOG_FRAC_BITS-2:0], sq[31]};
                n_v    = sq[31] ? sq[31:1] : sq[30:0];
                n_cnt  = r_cnt - CW'(1);
            end
            S_LOG: begin
                // |log2(x)| = (127 - exponent) * 2^F - fraction.
                n_a = {r_ediff, {LOG_FRAC_BITS{1'b0}}} - AW'(r_frac);
            end
            S_P0: begin
                n_acc = addend;
            end
            S_P1, S_P2, S_P3: begin
                n_acc = r_acc + addend;
            end
            S_CLAMP: begin
                n_res_fl = 1'b0;
                if (q > QW'(LEVEL_CLAMP)) begin
                    n_res_level = FLOOR_LEVEL;
                end else begin
                    n_res_level = 15'(q_neg);
                end
            end
            S_OUT: begin
                if (out_free) begin
                    n_o_valid   = 1'b1;
                    n_o_level   = r_res_level;
                    n_o_floored = r_res_fl;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_ready          = (r_state == S_IDLE);
    assign o_valid          = r_o_valid;
    assign o_level_millibel = r_o_level;
    assign o_floored        = r_o_floored;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_o_valid <= 1'b0;
            r_thresh  <= FLOOR_THRESH_RST;
            r_scale   <= SCALE_RST;
        end else begin
            r_state   <= n_state;
            r_o_valid <= n_o_valid;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_FLOOR_THRESHOLD: r_thresh <= i_cfg_data;
                    CFG_SCALE:           r_scale  <= i_cfg_data[15:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_v         <= n_v;
        r_ediff     <= n_ediff;
        r_cnt       <= n_cnt;
        r_frac      <= n_frac;
        r_m         <= n_m;
        r_a         <= n_a;
        r_acc       <= n_acc;
        r_res_level <= n_res_level;
        r_res_fl    <= n_res_fl;
        r_o_level   <= n_o_level;
        r_o_floored <= n_o_floored;
    end

endmodule
